// File: rtl/mwpo_pkg.sv
//------------------------------------------------------------------------------
// Multi-waveform phase oscillator package
// Shared widths, register indexes, waveform codes and controller commands.
//------------------------------------------------------------------------------
`default_nettype none

package mwpo_pkg;

   localparam int WAVE_W     = 2;
   localparam int FM_W       = 16;
   localparam int BASE_W     = 31;
   localparam int DEPTH_W    = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam int PROD1_W  = FM_W + DEPTH_W;
   localparam int PROD2_W  = BASE_W + PROD1_W;
   localparam int FM_SHIFT = 23;
   localparam int DELTA_W  = PROD2_W - FM_SHIFT;

   localparam logic [BASE_W-1:0] STEP_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_STEP = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FM_DEPTH  = 8'd1;

   localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd2;
   localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd3;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic finish;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/mwpo_req_if.sv
//------------------------------------------------------------------------------
// Oscillator request channel
// One word per sample tick: waveform select and modulation value.
//------------------------------------------------------------------------------
`default_nettype none

interface mwpo_req_if import mwpo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [WAVE_W-1:0]       wave_type;
   logic signed [FM_W-1:0]  fm_value;

   modport source (output valid, output wave_type, output fm_value, input ready);
   modport sink   (input valid, input wave_type, input fm_value, output ready);
endinterface

`default_nettype wire

// File: rtl/mwpo_rsp_if.sv
//------------------------------------------------------------------------------
// Oscillator response channel
// One word per sample tick: the generated sample.
//------------------------------------------------------------------------------
`default_nettype none

interface mwpo_rsp_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// File: rtl/mwpo_csr_if.sv
//------------------------------------------------------------------------------
// Oscillator configuration write channel
// One word per register write: register index and write data.
//------------------------------------------------------------------------------
`default_nettype none

interface mwpo_csr_if import mwpo_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/multi_waveform_phase_oscillator.sv
//------------------------------------------------------------------------------
// Multi-waveform phase oscillator
// Phase-accumulator oscillator with FM and sine, square, saw, triangle output.
//------------------------------------------------------------------------------
// Each request word is one sample tick. The block answers it with one sample
// taken from the phase before the tick, then adds the modulated step to the
// phase. A word passes through the accept, then the step multiply chain
// (modulation times depth, then times base step) with the sine table read
// alongside, then a final state that saturates the step and registers the
// sample. The response sits in its own register, so the next word is
// accepted while a sample waits to be taken; the sequence stalls in its
// last state only while an earlier sample is still unread.
`default_nettype none

module multi_waveform_phase_oscillator import mwpo_pkg::*; #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 8,
   parameter int SAMPLE_BITS     = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mwpo_req_if.sink    req,
   mwpo_rsp_if.source  rsp,
   mwpo_csr_if.sink    csr
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req.ready = req_ready;
   assign csr.ready = 1'b1;

   mwpo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mwpo_datapath #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_wave_type (req.wave_type),
      .req_fm_value  (req.fm_value),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_sample    (rsp.sample),
      .csr_valid     (csr.valid),
      .csr_index     (csr.index),
      .csr_data      (csr.data)
   );

endmodule

`default_nettype wire

// File: rtl/mwpo_ctrl.sv
//------------------------------------------------------------------------------
// Oscillator controller
// Sequences one sample through load, two multiply steps and finish.
//------------------------------------------------------------------------------
`default_nettype none

module mwpo_ctrl import mwpo_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL1 = 2'd1;
   localparam logic [1:0] ST_MUL2 = 2'd2;
   localparam logic [1:0] ST_STEP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       advance_ff;
   logic       advance_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load    = req_valid && req_ready;
      cmd.mul1    = (state_ff == ST_MUL1);
      cmd.mul2    = (state_ff == ST_MUL2);
      cmd.finish  = (state_ff == ST_STEP) && !status.rsp_busy;
      cmd.advance = advance_ff;
      advance_in  = cmd.finish;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         advance_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         advance_ff <= advance_in;
      end
   end

   a_finish_then_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> cmd.advance)
      else $error("phase advance did not follow a finished sample");

   a_load_starts_multiply: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_MUL1))
      else $error("accepted word did not start the multiply sequence");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.finish}))
      else $error("more than one sequencing command at once");

endmodule

`default_nettype wire

// File: rtl/mwpo_datapath.sv
//------------------------------------------------------------------------------
// Oscillator datapath
// Registers, FM step multiply chain, sine table, waveform shaping, phase.
//------------------------------------------------------------------------------
`default_nettype none

module mwpo_datapath import mwpo_pkg::*; #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 8,
   parameter int SAMPLE_BITS     = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output status_type                         status,
   input  wire logic [WAVE_W-1:0]             req_wave_type,
   input  wire logic signed [FM_W-1:0]        req_fm_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample,
   input  wire logic                          csr_valid,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int TB     = SINE_TABLE_BITS;
   localparam int SB     = SAMPLE_BITS;
   localparam int TAB_N  = 1 << TB;
   localparam int AMP_W  = SB - 1;
   localparam int EXT_A  = (PHASE_BITS > SB + 1) ? PHASE_BITS : SB + 1;
   localparam int EXT_W  = (EXT_A > TB + 2) ? EXT_A : TB + 2;
   localparam int TRI_W  = SB + 3;

   localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [AMP_W-1:0] rom_type [0:TAB_N];

   function automatic logic [AMP_W-1:0] sine_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] amp;
      x   = (HALF_PI_Q30 * 64'(i)) >> TB;
      x2  = (x * x) >> 30;
      t   = Q30_ONE;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s   = (x * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      amp = (64'd1 << AMP_W) - 64'd1;
      return AMP_W'((s * amp + (64'd1 << 29)) >> 30);
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i <= TAB_N; i++) begin
         r[i] = sine_entry(i);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [BASE_W-1:0]        base_step_ff;
   logic [DEPTH_W-1:0]       fm_depth_ff;
   logic [PHASE_BITS-1:0]    phase_ff;
   logic [WAVE_W-1:0]        wave_ff;
   logic                     fm_neg_ff;
   logic [FM_W-1:0]          fm_mag_ff;
   logic [PROD1_W-1:0]       prod1_ff;
   logic [PROD2_W-1:0]       prod2_ff;
   logic [TB:0]              rom_addr_ff;
   logic [TB:0]              rom_addr_in;
   logic [AMP_W-1:0]         rom_data_ff;
   logic [BASE_W-1:0]        step_ff;
   logic [BASE_W-1:0]        step_in;
   logic                     rsp_valid_ff;
   logic signed [SB-1:0]     rsp_sample_ff;
   logic signed [SB-1:0]     sample_in;

   logic [EXT_W-1:0]         ph_ext;
   logic [TB-1:0]            tab_idx;
   logic [DELTA_W-1:0]       delta;
   logic [DELTA_W:0]         step_sum;
   logic [SB-1:0]            saw_bits;
   logic [SB:0]              tri_q;
   logic signed [TRI_W-1:0]  tri_s;
   logic signed [TRI_W-1:0]  tri_v;
   logic signed [SB-1:0]     peak;

   localparam logic signed [TRI_W-1:0] TRI_F = TRI_W'(1) << (SB - 1);

   assign ph_ext  = EXT_W'(phase_ff) << (EXT_W - PHASE_BITS);
   assign tab_idx = ph_ext[EXT_W-3 -: TB];
   assign peak    = $signed({1'b0, {(SB-1){1'b1}}});

   always_comb begin
      if (ph_ext[EXT_W-2]) begin
         rom_addr_in = {1'b1, {TB{1'b0}}} - {1'b0, tab_idx};
      end else begin
         rom_addr_in = {1'b0, tab_idx};
      end
   end

   always_comb begin
      delta    = prod2_ff[PROD2_W-1:FM_SHIFT];
      step_sum = (DELTA_W+1)'(base_step_ff) + (DELTA_W+1)'(delta);
      if (fm_neg_ff) begin
         if (delta > DELTA_W'(base_step_ff)) begin
            step_in = '0;
         end else begin
            step_in = BASE_W'(DELTA_W'(base_step_ff) - delta);
         end
      end else if (step_sum > (DELTA_W+1)'(STEP_MAX)) begin
         step_in = STEP_MAX;
      end else begin
         step_in = step_sum[BASE_W-1:0];
      end
   end

   always_comb begin
      saw_bits = ph_ext[EXT_W-1 -: SB];
      tri_q    = ph_ext[EXT_W-1 -: SB+1];
      tri_s    = $signed(TRI_W'(tri_q));
      case (tri_q[SB:SB-1])
         2'b00:   tri_v = tri_s;
         2'b11:   tri_v = tri_s - (TRI_F <<< 2);
         default: tri_v = (TRI_F <<< 1) - tri_s;
      endcase
      if (tri_v > TRI_F - TRI_W'(1)) begin
         tri_v = TRI_F - TRI_W'(1);
      end
      case (wave_ff)
         WAVE_SINE: begin
            if (ph_ext[EXT_W-1]) begin
               sample_in = -$signed({1'b0, rom_data_ff});
            end else begin
               sample_in = $signed({1'b0, rom_data_ff});
            end
         end
         WAVE_SQUARE: begin
            sample_in = ph_ext[EXT_W-1] ? -peak : peak;
         end
         WAVE_SAW: begin
            sample_in = $signed({~saw_bits[SB-1], saw_bits[SB-2:0]});
         end
         default: begin
            sample_in = tri_v[SB-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff <= '0;
         fm_depth_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_STEP: base_step_ff <= csr_data[BASE_W-1:0];
            CSR_FM_DEPTH:  fm_depth_ff  <= csr_data[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.advance) begin
            phase_ff <= phase_ff + PHASE_BITS'(step_ff);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wave_ff   <= req_wave_type;
         fm_neg_ff <= req_fm_value[FM_W-1];
         fm_mag_ff <= req_fm_value[FM_W-1] ? FM_W'(-req_fm_value) : req_fm_value;
      end
      if (cmd.mul1) begin
         prod1_ff    <= PROD1_W'(fm_mag_ff) * PROD1_W'(fm_depth_ff);
         rom_addr_ff <= rom_addr_in;
      end
      if (cmd.mul2) begin
         prod2_ff    <= PROD2_W'(base_step_ff) * PROD2_W'(prod1_ff);
         rom_data_ff <= SINE_ROM[rom_addr_ff];
      end
      if (cmd.finish) begin
         step_ff       <= step_in;
         rsp_sample_ff <= sample_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished sample not presented on the response channel");

   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.advance |=> $stable(phase_ff))
      else $error("phase changed without an advance command");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending response word overwritten");

endmodule

`default_nettype wire

// File: test/multi_waveform_phase_oscillator_tb.sv
//------------------------------------------------------------------------------
// Multi-waveform phase oscillator testbench
// Sends sample ticks and register writes to the oscillator. A bit-accurate
// model of the phase accumulator, the modulated step and the four waveforms
// predicts each sample, and every response word is checked in order. The
// stimulus is a directed table followed by random rounds under changing
// idle and back-pressure patterns.
//------------------------------------------------------------------------------
module multi_waveform_phase_oscillator_tb;
   import mwpo_pkg::*;

   localparam int              CLOCK_HALF    = 10;
   localparam int              RESET_CYCLES  = 10;
   localparam int              SETTLE_CYCLES = 8;
   localparam int              CYCLE_LIMIT   = 200000;
   localparam int              HOLD_AT       = 300;
   localparam int              HOLD_CYCLES   = 200;
   localparam int              ROUNDS        = 4;
   localparam int              ROUND_WORDS   = 33;
   localparam int              REPORT_LIMIT  = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'hFF;
   localparam longint unsigned Q30_ONE       = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30   = 64'd1686629713;
   localparam longint          FULL_SCALE    = 32768;
   localparam longint          STEP_LIMIT    = 64'h7FFF_FFFF;

   typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  data;
      logic [WAVE_W-1:0]      wave;
      logic signed [FM_W-1:0] fm;
      bit                     typed;
      logic signed [15:0]     sample;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mwpo_req_if                     req_if ();
   mwpo_rsp_if #(.SAMPLE_BITS(16)) rsp_if ();
   mwpo_csr_if                     csr_if ();

   int                 sine_quarter [0:256];
   logic [31:0]        phase_acc;
   logic [BASE_W-1:0]  base_step;
   logic [DEPTH_W-1:0] fm_depth;
   logic signed [15:0] expected_samples [$];
   logic signed [15:0] oldest_sample;
   stim_row_type       directed_rows [$];
   int                 send_idle_pct  = 0;
   int                 rsp_stall_pct  = 0;
   int                 words_received = 0;
   int                 mismatches     = 0;
   int                 hold_left      = 0;
   int                 cycle_count    = 0;
   bit                 hold_done      = 1'b0;

   multi_waveform_phase_oscillator #(
      .PHASE_BITS(32),
      .SINE_TABLE_BITS(8),
      .SAMPLE_BITS(16)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic longint unsigned sine_q30(longint unsigned x);
      longint unsigned divisors [5];
      longint unsigned x2;
      longint unsigned t;
      divisors = '{110, 72, 42, 20, 6};
      x2 = (x * x) >> 30;
      t = Q30_ONE;
      for (int k = 0; k < 5; k++) begin
         t = Q30_ONE - ((x2 * t) >> 30) / divisors[k];
      end
      return (x * t) >> 30;
   endfunction

   function automatic logic signed [15:0] next_sample(logic [WAVE_W-1:0] wave,
                                                      logic signed [FM_W-1:0] fm);
      longint          fm_full;
      longint          step;
      longint          level;
      longint unsigned fm_mag;
      longint unsigned delta;
      logic [7:0]      slot;
      fm_full = fm;
      fm_mag  = (fm_full < 0) ? -fm_full : fm_full;
      delta   = (64'(base_step) * fm_mag * 64'(fm_depth)) >> 23;
      step    = longint'(base_step) + ((fm_full < 0) ? -longint'(delta) : longint'(delta));
      if (step < 0) step = 0;
      if (step > STEP_LIMIT) step = STEP_LIMIT;
      case (wave)
         WAVE_SINE: begin
            slot  = phase_acc[29:22];
            level = phase_acc[30] ? sine_quarter[256 - int'(slot)] : sine_quarter[slot];
            if (phase_acc[31]) level = -level;
         end
         WAVE_SQUARE: level = phase_acc[31] ? -(FULL_SCALE - 1) : FULL_SCALE - 1;
         WAVE_SAW: level = longint'(phase_acc[31:16]) - FULL_SCALE;
         default: begin
            level = longint'(phase_acc[31:15]);
            if (level >= 3 * FULL_SCALE) level = level - 4 * FULL_SCALE;
            else if (level >= FULL_SCALE) level = 2 * FULL_SCALE - level;
            if (level > FULL_SCALE - 1) level = FULL_SCALE - 1;
         end
      endcase
      phase_acc = phase_acc + step[31:0];
      return level[15:0];
   endfunction

   function automatic stim_row_type write_row(logic [CSR_IDX_W-1:0] index,
                                              logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{ROW_WRITE, index, data, '0, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type word_row(logic [WAVE_W-1:0] wave,
                                             logic signed [FM_W-1:0] fm);
      stim_row_type row;
      row = '{ROW_WORD, '0, '0, wave, fm, 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type known_row(logic [WAVE_W-1:0] wave,
                                              logic signed [FM_W-1:0] fm,
                                              logic signed [15:0] sample);
      stim_row_type row;
      row = '{ROW_WORD, '0, '0, wave, fm, 1'b1, sample};
      return row;
   endfunction

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      req_if.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      if (index == CSR_BASE_STEP) base_step = data[BASE_W-1:0];
      else if (index == CSR_FM_DEPTH) fm_depth = data[DEPTH_W-1:0];
   endtask

   task automatic send_word(logic [WAVE_W-1:0] wave, logic signed [FM_W-1:0] fm,
                            bit typed, logic signed [15:0] sample);
      logic signed [15:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.wave_type <= wave;
      req_if.fm_value  <= fm;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      predicted = next_sample(wave, fm);
      expected_samples.push_back(typed ? sample : predicted);
   endtask

   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) begin
         words_received++;
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected sample word: %0d", rsp_if.sample);
         end else begin
            oldest_sample = expected_samples.pop_front();
            if (rsp_if.sample !== oldest_sample) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("sample mismatch at word %0d: expected %0d, got %0d",
                           words_received, oldest_sample, rsp_if.sample);
            end
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && words_received >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      longint unsigned        angle;
      longint unsigned        level;
      logic [CSR_DATA_W-1:0]  base_data;
      logic [CSR_DATA_W-1:0]  depth_data;
      logic signed [FM_W-1:0] fm;

      req_if.valid     = 1'b0;
      req_if.wave_type = '0;
      req_if.fm_value  = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      phase_acc        = '0;
      base_step        = '0;
      fm_depth         = '0;

      for (int i = 0; i <= 256; i++) begin
         angle = (HALF_PI_Q30 * i) / 256;
         level = sine_q30(angle);
         if (level > Q30_ONE) level = Q30_ONE;
         sine_quarter[i] = int'((level * 32767 + (64'd1 << 29)) >> 30);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      directed_rows.push_back(known_row(WAVE_SINE, 16'sh0000, 16'sd0));
      directed_rows.push_back(known_row(WAVE_SQUARE, 16'sh0000, 16'sd32767));
      directed_rows.push_back(known_row(WAVE_SAW, 16'sh8000, 16'sh8000));
      directed_rows.push_back(known_row(WAVE_TRIANGLE, 16'sh7FFF, 16'sd0));
      directed_rows.push_back(write_row(CSR_BASE_STEP, 32'h4000_0000));
      directed_rows.push_back(write_row(CSR_FM_DEPTH, 32'h0000_0000));
      directed_rows.push_back(word_row(WAVE_TRIANGLE, 16'sh0000));
      directed_rows.push_back(word_row(WAVE_TRIANGLE, 16'sh7FFF));
      directed_rows.push_back(word_row(WAVE_SQUARE, 16'sh8000));
      directed_rows.push_back(word_row(WAVE_SAW, 16'sh0000));
      directed_rows.push_back(word_row(WAVE_SINE, 16'sh0000));
      directed_rows.push_back(word_row(WAVE_SINE, 16'sh0000));
      directed_rows.push_back(write_row(CSR_BASE_STEP, 32'hFFFF_FFFF));
      directed_rows.push_back(write_row(CSR_FM_DEPTH, 32'hFFFF_FFFF));
      directed_rows.push_back(write_row(CSR_UNUSED_LO, 32'h1234_5678));
      directed_rows.push_back(write_row(CSR_UNUSED_HI, 32'hFFFF_FFFF));
      directed_rows.push_back(word_row(WAVE_SAW, 16'sh7FFF));
      directed_rows.push_back(word_row(WAVE_SAW, 16'sh8000));
      directed_rows.push_back(word_row(WAVE_SAW, 16'sh8000));
      directed_rows.push_back(word_row(WAVE_SINE, 16'sh0001));
      directed_rows.push_back(word_row(WAVE_SQUARE, 16'shFFFF));
      directed_rows.push_back(word_row(WAVE_TRIANGLE, 16'sh4000));
      directed_rows.push_back(write_row(CSR_FM_DEPTH, 32'h0000_0100));
      directed_rows.push_back(write_row(CSR_BASE_STEP, 32'h0001_2345));
      directed_rows.push_back(word_row(WAVE_SINE, 16'sh7FFF));
      directed_rows.push_back(word_row(WAVE_SQUARE, 16'sh8000));
      directed_rows.push_back(word_row(WAVE_SAW, 16'sh1234));
      directed_rows.push_back(word_row(WAVE_TRIANGLE, 16'shEDCC));
      directed_rows.push_back(word_row(WAVE_SINE, 16'shFFFF));

      send_idle_pct = 9;
      rsp_stall_pct = 77;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE)
            write_register(directed_rows[r].index, directed_rows[r].data);
         else
            send_word(directed_rows[r].wave, directed_rows[r].fm,
                      directed_rows[r].typed, directed_rows[r].sample);
      end

      for (int stage = 0; stage < 3; stage++) begin
         send_idle_pct = (stage == 0) ? 9 : (stage == 1) ? 77 : 0;
         rsp_stall_pct = (stage == 0) ? 77 : (stage == 1) ? 9 : 0;
         for (int round = 0; round < ROUNDS; round++) begin
            case (round)
               0: begin
                  base_data  = $urandom_range(32'h0010_0000);
                  depth_data = $urandom_range(32'h0000_0200);
               end
               1: begin
                  base_data  = 32'hFFFF_FFFF;
                  depth_data = 32'hFFFF_FFFF;
               end
               2: begin
                  base_data  = 32'h0000_0000;
                  depth_data = $urandom();
               end
               default: begin
                  base_data  = $urandom();
                  depth_data = $urandom_range(32'h0000_0800);
               end
            endcase
            write_register(CSR_FM_DEPTH, depth_data);
            write_register(CSR_BASE_STEP, base_data);
            if ($urandom_range(3) == 0)
               write_register(CSR_IDX_W'($urandom_range(255, 2)), $urandom());
            for (int n = 0; n < ROUND_WORDS; n++) begin
               fm = FM_W'($urandom());
               if ($urandom_range(7) == 0) begin
                  case ($urandom_range(3))
                     0: fm = 16'sh8000;
                     1: fm = 16'sh7FFF;
                     2: fm = 16'sh0000;
                     default: fm = 16'shFFFF;
                  endcase
               end
               send_word(WAVE_W'($urandom_range(3)), fm, 1'b0, '0);
            end
         end
      end

      req_if.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
